FILE: hw/rtl/rfc_pkg.sv
// ----------------------------------------------------------------------------
// rfc_pkg
// Types and constants shared by the receive frame classifier modules.
// ----------------------------------------------------------------------------
package rfc_pkg;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 64;
  localparam int unsigned FlagCount = 12;

  typedef enum logic [1:0] {
    CLASS_NONE = 2'd0,
    CLASS_ARP  = 2'd1,
    CLASS_PING = 2'd2,
    CLASS_UDP  = 2'd3
  } frame_class_t;

  typedef enum logic [1:0] {
    REG_OWN_MAC  = 2'd0,
    REG_OWN_IP   = 2'd1,
    REG_UDP_PORT = 2'd2
  } reg_index_t;

  localparam int unsigned FLAG_DST_BCAST  = 0;
  localparam int unsigned FLAG_DST_OWN    = 1;
  localparam int unsigned FLAG_SRC_OWN    = 2;
  localparam int unsigned FLAG_ARP_HDR    = 3;
  localparam int unsigned FLAG_ARP_TIP    = 4;
  localparam int unsigned FLAG_ETH_IPV4   = 5;
  localparam int unsigned FLAG_IP_VER     = 6;
  localparam int unsigned FLAG_IP_DST     = 7;
  localparam int unsigned FLAG_PROTO_ICMP = 8;
  localparam int unsigned FLAG_PROTO_UDP  = 9;
  localparam int unsigned FLAG_ICMP_ECHO  = 10;
  localparam int unsigned FLAG_UDP_PORT   = 11;

  localparam logic [15:0] ETH_TYPE_ARP   = 16'h0806;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ARP_HTYPE_ETH  = 16'h0001;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [7:0]  IP_PROTO_ICMP  = 8'h01;
  localparam logic [7:0]  IP_PROTO_UDP   = 8'h11;
  localparam logic [7:0]  ICMP_ECHO_REQ  = 8'h08;
  localparam logic [7:0]  ICMP_CODE_ZERO = 8'h00;
  localparam logic [7:0]  BCAST_BYTE     = 8'hff;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
  localparam logic [15:0] UDP_LEN_LIMIT  = 16'd1512;
  localparam logic [15:0] UDP_PORT_RESET = 16'd4950;
  localparam logic [5:0]  POS_MAX        = 6'd63;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       end_of_frame;
  } rfc_in_t;

  typedef struct packed {
    frame_class_t frame_class;
    logic [10:0]  body_length;
  } rfc_out_t;

  typedef struct packed {
    logic [47:0] own_mac;
    logic [31:0] own_ip;
    logic [15:0] udp_port;
  } rfc_cfg_t;

endpackage

FILE: hw/rtl/rfc_cfg_regs.sv
// ----------------------------------------------------------------------------
// rfc_cfg_regs
// APB register file holding the own MAC address, own IP address and UDP port.
// ----------------------------------------------------------------------------
module rfc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfc_pkg::AddrWidth-1:0] paddr,
  input  logic [rfc_pkg::DataWidth-1:0] pwdata,
  output logic [rfc_pkg::DataWidth-1:0] prdata,
  output logic                          pready,
  output rfc_pkg::rfc_cfg_t             cfg
);

  rfc_pkg::reg_index_t index;
  logic                write_en;

  assign index    = rfc_pkg::reg_index_t'(paddr[4:3]);
  assign pready   = 1'b1;
  assign write_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_mac  <= '0;
      cfg.own_ip   <= '0;
      cfg.udp_port <= rfc_pkg::UDP_PORT_RESET;
    end else if (write_en) begin
      unique case (index)
        rfc_pkg::REG_OWN_MAC:  cfg.own_mac  <= pwdata[47:0];
        rfc_pkg::REG_OWN_IP:   cfg.own_ip   <= pwdata[31:0];
        rfc_pkg::REG_UDP_PORT: cfg.udp_port <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      rfc_pkg::REG_OWN_MAC:  prdata = {16'd0, cfg.own_mac};
      rfc_pkg::REG_OWN_IP:   prdata = {32'd0, cfg.own_ip};
      rfc_pkg::REG_UDP_PORT: prdata = {48'd0, cfg.udp_port};
      default:               prdata = '0;
    endcase
  end

endmodule

FILE: hw/rtl/rfc_hdr_match.sv
// ----------------------------------------------------------------------------
// rfc_hdr_match
// Per-byte header comparison, frame state and end-of-frame classification.
// ----------------------------------------------------------------------------
module rfc_hdr_match (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  rfc_pkg::rfc_in_t  item,
  input  rfc_pkg::rfc_cfg_t cfg,
  output rfc_pkg::rfc_out_t result
);

  logic [5:0]                    byte_position;
  logic [rfc_pkg::FlagCount-1:0] match_flags;
  logic [15:0]                   udp_length;
  logic [5:0]                    byte_position_next;
  logic [rfc_pkg::FlagCount-1:0] match_flags_next;
  logic [15:0]                   udp_length_next;
  logic [7:0]                    b;
  logic [5:0]                    p;
  logic                          eth_ip;
  logic [15:0]                   body;

  function automatic logic [7:0] mac_byte(input logic [47:0] mac, input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = mac[47:40];
      3'd1:    r = mac[39:32];
      3'd2:    r = mac[31:24];
      3'd3:    r = mac[23:16];
      3'd4:    r = mac[15:8];
      3'd5:    r = mac[7:0];
      default: r = 8'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] ip_byte(input logic [31:0] ip, input logic [1:0] i);
    logic [7:0] r;
    unique case (i)
      2'd0: r = ip[31:24];
      2'd1: r = ip[23:16];
      2'd2: r = ip[15:8];
      2'd3: r = ip[7:0];
    endcase
    return r;
  endfunction

  assign b = item.frame_byte;
  assign p = byte_position;

  always_comb begin
    match_flags_next = match_flags;
    udp_length_next  = udp_length;
    if (p < 6'd6) begin
      if (b != rfc_pkg::BCAST_BYTE) match_flags_next[rfc_pkg::FLAG_DST_BCAST] = 1'b0;
      if (b != mac_byte(cfg.own_mac, p[2:0])) match_flags_next[rfc_pkg::FLAG_DST_OWN] = 1'b0;
    end else if (p < 6'd12) begin
      if (b != mac_byte(cfg.own_mac, 3'(p - 6'd6)))
        match_flags_next[rfc_pkg::FLAG_SRC_OWN] = 1'b0;
    end else if (p == 6'd12) begin
      if (b != rfc_pkg::ETH_TYPE_ARP[15:8]) match_flags_next[rfc_pkg::FLAG_ARP_HDR] = 1'b0;
      if (b != rfc_pkg::ETHERTYPE_IPV4[15:8]) match_flags_next[rfc_pkg::FLAG_ETH_IPV4] = 1'b0;
    end else if (p == 6'd13) begin
      if (b != rfc_pkg::ETH_TYPE_ARP[7:0]) match_flags_next[rfc_pkg::FLAG_ARP_HDR] = 1'b0;
      if (b != rfc_pkg::ETHERTYPE_IPV4[7:0]) match_flags_next[rfc_pkg::FLAG_ETH_IPV4] = 1'b0;
    end else if (p == 6'd14) begin
      if (b != rfc_pkg::ARP_HTYPE_ETH[15:8]) match_flags_next[rfc_pkg::FLAG_ARP_HDR] = 1'b0;
      if (b != rfc_pkg::IP_VER_IHL) match_flags_next[rfc_pkg::FLAG_IP_VER] = 1'b0;
    end else if (p == 6'd15) begin
      if (b != rfc_pkg::ARP_HTYPE_ETH[7:0]) match_flags_next[rfc_pkg::FLAG_ARP_HDR] = 1'b0;
    end else if (p == 6'd23) begin
      if (b != rfc_pkg::IP_PROTO_ICMP) match_flags_next[rfc_pkg::FLAG_PROTO_ICMP] = 1'b0;
      if (b != rfc_pkg::IP_PROTO_UDP) match_flags_next[rfc_pkg::FLAG_PROTO_UDP] = 1'b0;
    end else if (p >= 6'd30 && p < 6'd34) begin
      if (b != ip_byte(cfg.own_ip, 2'(p - 6'd30)))
        match_flags_next[rfc_pkg::FLAG_IP_DST] = 1'b0;
    end else if (p == 6'd34) begin
      if (b != rfc_pkg::ICMP_ECHO_REQ) match_flags_next[rfc_pkg::FLAG_ICMP_ECHO] = 1'b0;
    end else if (p == 6'd35) begin
      if (b != rfc_pkg::ICMP_CODE_ZERO) match_flags_next[rfc_pkg::FLAG_ICMP_ECHO] = 1'b0;
    end else if (p == 6'd36) begin
      if (b != cfg.udp_port[15:8]) match_flags_next[rfc_pkg::FLAG_UDP_PORT] = 1'b0;
    end else if (p == 6'd37) begin
      if (b != cfg.udp_port[7:0]) match_flags_next[rfc_pkg::FLAG_UDP_PORT] = 1'b0;
    end
    if (p == 6'd38) begin
      udp_length_next = {b, 8'd0};
    end else if (p == 6'd39) begin
      udp_length_next = {udp_length[15:8], b};
    end
    if (p >= 6'd38 && p < 6'd42) begin
      if (b != ip_byte(cfg.own_ip, 2'(p - 6'd38)))
        match_flags_next[rfc_pkg::FLAG_ARP_TIP] = 1'b0;
    end
  end

  assign eth_ip = match_flags_next[rfc_pkg::FLAG_DST_OWN] &&
                  match_flags_next[rfc_pkg::FLAG_ETH_IPV4] &&
                  match_flags_next[rfc_pkg::FLAG_IP_VER] &&
                  match_flags_next[rfc_pkg::FLAG_IP_DST];
  assign body   = udp_length_next - rfc_pkg::UDP_HDR_LEN;

  always_comb begin
    result.frame_class = rfc_pkg::CLASS_NONE;
    result.body_length = '0;
    priority if (p >= 6'd41 && match_flags_next[rfc_pkg::FLAG_ARP_HDR] &&
                 match_flags_next[rfc_pkg::FLAG_ARP_TIP] &&
                 (match_flags_next[rfc_pkg::FLAG_DST_BCAST] ||
                  match_flags_next[rfc_pkg::FLAG_DST_OWN]) &&
                 !match_flags_next[rfc_pkg::FLAG_SRC_OWN]) begin
      result.frame_class = rfc_pkg::CLASS_ARP;
    end else if (p >= 6'd35 && eth_ip && match_flags_next[rfc_pkg::FLAG_PROTO_ICMP] &&
                 match_flags_next[rfc_pkg::FLAG_ICMP_ECHO]) begin
      result.frame_class = rfc_pkg::CLASS_PING;
    end else if (p >= 6'd39 && eth_ip && match_flags_next[rfc_pkg::FLAG_PROTO_UDP] &&
                 match_flags_next[rfc_pkg::FLAG_UDP_PORT] &&
                 udp_length_next >= rfc_pkg::UDP_HDR_LEN &&
                 udp_length_next < rfc_pkg::UDP_LEN_LIMIT) begin
      result.frame_class = rfc_pkg::CLASS_UDP;
      result.body_length = body[10:0];
    end else begin
      result.frame_class = rfc_pkg::CLASS_NONE;
    end
  end

  assign byte_position_next = (p < rfc_pkg::POS_MAX) ? p + 6'd1 : p;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      match_flags   <= '1;
      udp_length    <= '0;
    end else if (step) begin
      if (item.end_of_frame) begin
        byte_position <= '0;
        match_flags   <= '1;
        udp_length    <= '0;
      end else begin
        byte_position <= byte_position_next;
        match_flags   <= match_flags_next;
        udp_length    <= udp_length_next;
      end
    end
  end

endmodule

FILE: hw/rtl/rx_frame_classifier_core.sv
// ----------------------------------------------------------------------------
// rx_frame_classifier_core
// Receive-side Ethernet classifier for ARP, ping and UDP frames addressed to us.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in      | input     | in_valid/in_ready  | in_item (frame_byte, end_of_frame)
//  out     | output    | out_valid/out_ready| out_item (frame_class, body_length)
//  apb     | input     | psel/penable       | paddr, pwdata, prdata
//
// One byte is taken per cycle unless a final byte stalls in the input register.
// The classification is written to the result register at the edge at which
// the last byte leaves the input register.
// Only a final byte stalls while a result is still waiting on out_ready.
// Reset clears the frame state and sets udp_port to 4950.
module rx_frame_classifier_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rfc_pkg::rfc_in_t              in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rfc_pkg::rfc_out_t             out_item,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rfc_pkg::AddrWidth-1:0] paddr,
  input  logic [rfc_pkg::DataWidth-1:0] pwdata,
  output logic [rfc_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);

  rfc_pkg::rfc_cfg_t cfg;
  rfc_pkg::rfc_in_t  stage_item;
  rfc_pkg::rfc_out_t result;
  logic              stage_valid;
  logic              stage_fire;

  rfc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfc_hdr_match u_match (
    .clk    (clk),
    .rst    (rst),
    .step   (stage_fire),
    .item   (stage_item),
    .cfg    (cfg),
    .result (result)
  );

  assign stage_fire = stage_valid && (!stage_item.end_of_frame || !out_valid || out_ready);
  assign in_ready   = !stage_valid || stage_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      stage_item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_fire && stage_item.end_of_frame) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && stage_item.end_of_frame) begin
      out_item <= result;
    end
  end

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> in_ready)
    else $error("input register empty but not ready");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (stage_fire && stage_item.end_of_frame) |=> out_valid)
    else $error("final byte processed without a result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !(stage_fire && stage_item.end_of_frame)) |=> !out_valid)
    else $error("result repeated after it was taken");

  a_body_only_udp: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.frame_class != rfc_pkg::CLASS_UDP) |-> out_item.body_length == '0)
    else $error("body length set for a frame that is not UDP");

endmodule
